>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Fixed-delay implication, held off during reset
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

>>> hdl/qrs_pkg.sv
package qrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_BITS = 16;
  localparam int OUT_BITS  = 34;

  // |b*b - 4ac| stays below 2^(2*COEF_BITS+1)
  localparam int MAG_BITS  = 2 * COEF_BITS + 2;
  localparam int RAD_BITS  = MAG_BITS + 2 * FRAC_BITS;
  localparam int SQ_STEPS  = RAD_BITS / 2;
  localparam int ROOT_BITS = SQ_STEPS;
  localparam int REM_BITS  = ROOT_BITS + 3;

  // numerator -b*2^F +/- s, signed
  localparam int NUM_BITS  = ROOT_BITS + 2;
  localparam int QMAG_BITS = NUM_BITS - 1;
  localparam int DEN_BITS  = COEF_BITS + 2;
  localparam int DMAG_BITS = COEF_BITS + 1;
  localparam int DIV_STEPS = QMAG_BITS;

  localparam int DISC_LAT  = 2;
  localparam int LATENCY   = 1 + DISC_LAT + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam int SAT_BITS  = ((NUM_BITS > OUT_BITS) ? NUM_BITS : OUT_BITS) + 1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DISTINCT = 2'd0;
  localparam kind_t KIND_EQUAL    = 2'd1;
  localparam kind_t KIND_COMPLEX  = 2'd2;
  localparam kind_t KIND_DEGEN    = 2'd3;

  // Per-request data from the discriminant stage
  typedef struct packed {
    logic                       valid;
    logic                       a_zero;
    logic                       d_neg;
    logic                       d_zero;
    logic signed [NUM_BITS-1:0] negb;
    logic signed [DEN_BITS-1:0] den;
  } disc_t;

  // Per-request control alongside the dividers
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

  // Clamp a quotient to the output range
  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [NUM_BITS-1:0] v);
    logic signed [SAT_BITS-1:0] w;
    logic signed [SAT_BITS-1:0] hi;
    logic signed [SAT_BITS-1:0] lo;
    w  = SAT_BITS'(v);
    hi = $signed({{(SAT_BITS-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}});
    lo = -hi - SAT_BITS'(1);
    if (w > hi) begin
      w = hi;
    end else if (w < lo) begin
      w = lo;
    end
    return OUT_BITS'(w);
  endfunction

endpackage

>>> hdl/quadratic_root_solver_top.sv
// Throughput: one request per cycle; busy stays low, set by the fully pipelined
// square root (one root bit per stage) and dividers (one quotient bit per stage).
// Reset (rst, synchronous) clears all valid bits; requests in flight are dropped.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module quadratic_root_solver_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] coef_c,
  output logic                                 done,
  output logic [1:0]                           root_kind,
  output logic signed [qrs_pkg::OUT_BITS-1:0]  first_value,
  output logic signed [qrs_pkg::OUT_BITS-1:0]  second_value
);
  import qrs_pkg::*;

`include "assert_macros.svh"

  logic                        in_v;
  logic signed [COEF_BITS-1:0] in_a;
  logic signed [COEF_BITS-1:0] in_b;
  logic signed [COEF_BITS-1:0] in_c;

  disc_t                       disc_side;
  logic [MAG_BITS-1:0]         disc_mag;
  logic [ROOT_BITS-1:0]        sq_root;
  disc_t                       sq_line [SQ_STEPS];
  disc_t                       sq_side;

  ctl_t                        num_ctl;
  logic signed [NUM_BITS-1:0]  num1;
  logic signed [NUM_BITS-1:0]  num2;
  logic signed [DEN_BITS-1:0]  num_den;
  kind_t                       kind_next;
  logic signed [NUM_BITS-1:0]  s_ext;

  ctl_t                        div_line [DIV_STEPS];
  logic signed [NUM_BITS-1:0]  quo1;
  logic signed [NUM_BITS-1:0]  quo2;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    in_a <= coef_a;
    in_b <= coef_b;
    in_c <= coef_c;
  end

  qrs_disc u_disc (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_v),
    .a        (in_a),
    .b        (in_b),
    .c        (in_c),
    .side     (disc_side),
    .mag      (disc_mag)
  );

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .mag  (disc_mag),
    .root (sq_root)
  );

  // Request data alongside the square root pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_line[i].valid <= 1'b0;
      end
    end else begin
      sq_line[0].valid <= disc_side.valid;
      for (int i = 1; i < SQ_STEPS; i++) begin
        sq_line[i].valid <= sq_line[i-1].valid;
      end
    end
    sq_line[0].a_zero <= disc_side.a_zero;
    sq_line[0].d_neg  <= disc_side.d_neg;
    sq_line[0].d_zero <= disc_side.d_zero;
    sq_line[0].negb   <= disc_side.negb;
    sq_line[0].den    <= disc_side.den;
    for (int i = 1; i < SQ_STEPS; i++) begin
      sq_line[i].a_zero <= sq_line[i-1].a_zero;
      sq_line[i].d_neg  <= sq_line[i-1].d_neg;
      sq_line[i].d_zero <= sq_line[i-1].d_zero;
      sq_line[i].negb   <= sq_line[i-1].negb;
      sq_line[i].den    <= sq_line[i-1].den;
    end
  end

  assign sq_side = sq_line[SQ_STEPS-1];

  // Classify and form the numerators
  always_comb begin
    s_ext = $signed(NUM_BITS'(sq_root));
    if (sq_side.a_zero) begin
      kind_next = KIND_DEGEN;
    end else if (sq_side.d_neg) begin
      kind_next = KIND_COMPLEX;
    end else if (sq_side.d_zero) begin
      kind_next = KIND_EQUAL;
    end else begin
      kind_next = KIND_DISTINCT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_ctl.valid <= 1'b0;
    end else begin
      num_ctl.valid <= sq_side.valid;
    end
    num_ctl.kind <= kind_next;
    num_den      <= sq_side.den;
    case (kind_next)
      KIND_COMPLEX: begin
        num1 <= sq_side.negb;
        num2 <= s_ext;
      end
      KIND_DISTINCT: begin
        num1 <= sq_side.negb + s_ext;
        num2 <= sq_side.negb - s_ext;
      end
      default: begin
        num1 <= sq_side.negb;
        num2 <= sq_side.negb;
      end
    endcase
  end

  qrs_div u_div1 (
    .clk (clk),
    .num (num1),
    .den (num_den),
    .quo (quo1)
  );

  qrs_div u_div2 (
    .clk (clk),
    .num (num2),
    .den (num_den),
    .quo (quo2)
  );

  // Control alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_line[i].valid <= 1'b0;
      end
    end else begin
      div_line[0].valid <= num_ctl.valid;
      for (int i = 1; i < DIV_STEPS; i++) begin
        div_line[i].valid <= div_line[i-1].valid;
      end
    end
    div_line[0].kind <= num_ctl.kind;
    for (int i = 1; i < DIV_STEPS; i++) begin
      div_line[i].kind <= div_line[i-1].kind;
    end
  end

  // Output register; degenerate requests report zero roots
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_line[DIV_STEPS-1].valid;
    end
    root_kind <= div_line[DIV_STEPS-1].kind;
    if (div_line[DIV_STEPS-1].kind == KIND_DEGEN) begin
      first_value  <= '0;
      second_value <= '0;
    end else begin
      first_value  <= sat_out(quo1);
      second_value <= sat_out(quo2);
    end
  end

  `ASSERT_DELAY(a_latency, clk, rst, start && !busy, LATENCY, done, "result strobe missing after fixed latency")
  `ASSERT_IMPLY(a_degen_zero, clk, rst, done && (root_kind == KIND_DEGEN), (first_value == '0) && (second_value == '0), "degenerate result not zero")
  `ASSERT_IMPLY(a_equal_same, clk, rst, done && (root_kind == KIND_EQUAL), first_value == second_value, "equal roots differ")

endmodule

>>> hdl/qrs_disc.sv
module qrs_disc (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] a,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] b,
  input  logic signed [qrs_pkg::COEF_BITS-1:0] c,
  output qrs_pkg::disc_t                       side,
  output logic [qrs_pkg::MAG_BITS-1:0]         mag
);
  import qrs_pkg::*;

  localparam int PW = 2 * COEF_BITS;

  logic                        v1;
  logic signed [COEF_BITS-1:0] a1;
  logic signed [COEF_BITS-1:0] b1;
  logic signed [PW-1:0]        bb;
  logic signed [PW-1:0]        ac;

  logic signed [MAG_BITS:0]    d;
  logic [MAG_BITS:0]           d_abs;
  disc_t                       side_next;

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    a1 <= a;
    b1 <= b;
    bb <= b * b;
    ac <= a * c;
  end

  // Stage 2: d = b*b - 4ac, its magnitude and the division operands
  always_comb begin
    d = $signed({{(MAG_BITS+1-PW){bb[PW-1]}}, bb})
      - $signed({{(MAG_BITS-1-PW){ac[PW-1]}}, ac, 2'b00});
    d_abs = d[MAG_BITS] ? -d : d;
    side_next.valid  = v1;
    side_next.a_zero = (a1 == '0);
    side_next.d_neg  = d[MAG_BITS];
    side_next.d_zero = (d == '0);
    side_next.negb   = -($signed(NUM_BITS'(b1)) <<< FRAC_BITS);
    side_next.den    = $signed(DEN_BITS'(a1)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= side_next.valid;
    end
    side.a_zero <= side_next.a_zero;
    side.d_neg  <= side_next.d_neg;
    side.d_zero <= side_next.d_zero;
    side.negb   <= side_next.negb;
    side.den    <= side_next.den;
    mag         <= d_abs[MAG_BITS-1:0];
  end

endmodule

>>> hdl/qrs_sqrt.sv
module qrs_sqrt (
  input  logic                          clk,
  input  logic [qrs_pkg::MAG_BITS-1:0]  mag,
  output logic [qrs_pkg::ROOT_BITS-1:0] root
);
  import qrs_pkg::*;

  logic [REM_BITS-1:0]  rem_r  [SQ_STEPS];
  logic [ROOT_BITS-1:0] root_r [SQ_STEPS];
  logic [RAD_BITS-1:0]  rad_r  [SQ_STEPS];

  logic [REM_BITS-1:0]  rem_in  [SQ_STEPS];
  logic [ROOT_BITS-1:0] root_in [SQ_STEPS];
  logic [RAD_BITS-1:0]  rad_in  [SQ_STEPS];
  logic [REM_BITS-1:0]  rem_n   [SQ_STEPS];
  logic [ROOT_BITS-1:0] root_n  [SQ_STEPS];
  logic [RAD_BITS-1:0]  rad_n   [SQ_STEPS];

  // One root bit per stage: bring down two radicand bits, trial subtract
  always_comb begin
    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = RAD_BITS'(mag) << (2 * FRAC_BITS);
    for (int i = 1; i < SQ_STEPS; i++) begin
      rem_in[i]  = rem_r[i-1];
      root_in[i] = root_r[i-1];
      rad_in[i]  = rad_r[i-1];
    end
    for (int i = 0; i < SQ_STEPS; i++) begin
      rem_sh = {rem_in[i][REM_BITS-3:0], rad_in[i][RAD_BITS-1 -: 2]};
      trial  = {1'b0, root_in[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_n[i]  = rem_sh - trial;
        root_n[i] = {root_in[i][ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_n[i]  = rem_sh;
        root_n[i] = {root_in[i][ROOT_BITS-2:0], 1'b0};
      end
      rad_n[i] = {rad_in[i][RAD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQ_STEPS; i++) begin
      rem_r[i]  <= rem_n[i];
      root_r[i] <= root_n[i];
      rad_r[i]  <= rad_n[i];
    end
  end

  assign root = root_r[SQ_STEPS-1];

endmodule

>>> hdl/qrs_div.sv
module qrs_div (
  input  logic                                clk,
  input  logic signed [qrs_pkg::NUM_BITS-1:0] num,
  input  logic signed [qrs_pkg::DEN_BITS-1:0] den,
  output logic signed [qrs_pkg::NUM_BITS-1:0] quo
);
  import qrs_pkg::*;

  logic [DMAG_BITS-1:0] rem_r [DIV_STEPS];
  logic [QMAG_BITS-1:0] nm_r  [DIV_STEPS];
  logic [QMAG_BITS-1:0] q_r   [DIV_STEPS];
  logic [DMAG_BITS-1:0] dm_r  [DIV_STEPS];
  logic                 neg_r [DIV_STEPS];

  logic [DMAG_BITS-1:0] rem_in [DIV_STEPS];
  logic [QMAG_BITS-1:0] nm_in  [DIV_STEPS];
  logic [QMAG_BITS-1:0] q_in   [DIV_STEPS];
  logic [DMAG_BITS-1:0] dm_in  [DIV_STEPS];
  logic                 neg_in [DIV_STEPS];
  logic [DMAG_BITS-1:0] rem_n  [DIV_STEPS];
  logic [QMAG_BITS-1:0] q_n    [DIV_STEPS];

  logic [NUM_BITS-1:0]  num_abs;
  logic [DEN_BITS-1:0]  den_abs;
  logic [QMAG_BITS-1:0] q_last;

  // Restoring division on magnitudes, one quotient bit per stage
  always_comb begin
    logic [DMAG_BITS:0] rem_sh;
    num_abs   = num[NUM_BITS-1] ? -num : num;
    den_abs   = den[DEN_BITS-1] ? -den : den;
    rem_in[0] = '0;
    nm_in[0]  = num_abs[QMAG_BITS-1:0];
    q_in[0]   = '0;
    dm_in[0]  = den_abs[DMAG_BITS-1:0];
    neg_in[0] = num[NUM_BITS-1] ^ den[DEN_BITS-1];
    for (int i = 1; i < DIV_STEPS; i++) begin
      rem_in[i] = rem_r[i-1];
      nm_in[i]  = nm_r[i-1];
      q_in[i]   = q_r[i-1];
      dm_in[i]  = dm_r[i-1];
      neg_in[i] = neg_r[i-1];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_sh = {rem_in[i], nm_in[i][QMAG_BITS-1]};
      if (rem_sh >= {1'b0, dm_in[i]}) begin
        rem_n[i] = DMAG_BITS'(rem_sh - {1'b0, dm_in[i]});
        q_n[i]   = {q_in[i][QMAG_BITS-2:0], 1'b1};
      end else begin
        rem_n[i] = rem_sh[DMAG_BITS-1:0];
        q_n[i]   = {q_in[i][QMAG_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_r[i] <= rem_n[i];
      nm_r[i]  <= {nm_in[i][QMAG_BITS-2:0], 1'b0};
      q_r[i]   <= q_n[i];
      dm_r[i]  <= dm_in[i];
      neg_r[i] <= neg_in[i];
    end
  end

  // Truncation toward zero: sign applied to the magnitude quotient
  assign q_last = q_r[DIV_STEPS-1];
  assign quo = neg_r[DIV_STEPS-1] ? -$signed({1'b0, q_last}) : $signed({1'b0, q_last});

endmodule
